// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define CHECK_LIVE(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ialu_pkg.sv -----
package ialu_pkg;

  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_MOD = 5'd4;
  localparam logic [4:0] OP_POW = 5'd5;
  localparam logic [4:0] OP_AND = 5'd6;
  localparam logic [4:0] OP_OR  = 5'd7;
  localparam logic [4:0] OP_XOR = 5'd8;
  localparam logic [4:0] OP_SHL = 5'd9;
  localparam logic [4:0] OP_SHR = 5'd10;
  localparam logic [4:0] OP_EQ  = 5'd11;
  localparam logic [4:0] OP_NEQ = 5'd12;
  localparam logic [4:0] OP_LT  = 5'd13;
  localparam logic [4:0] OP_GT  = 5'd14;
  localparam logic [4:0] OP_LTE = 5'd15;
  localparam logic [4:0] OP_GTE = 5'd16;
  localparam logic [4:0] OP_LAND = 5'd17;
  localparam logic [4:0] OP_LOR  = 5'd18;

  // Which part of the back end carries an operation out.
  localparam logic [1:0] CLS_SIMPLE = 2'd0;
  localparam logic [1:0] CLS_MUL    = 2'd1;
  localparam logic [1:0] CLS_DIV    = 2'd2;
  localparam logic [1:0] CLS_POW    = 2'd3;

  typedef struct packed {
    logic [4:0]         action;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               error_flag;
  } rsp_t;

  typedef struct packed {
    logic [1:0] cls;
    req_t       req;
  } cmd_t;

endpackage

// ----- rtl/int64_interpreter_alu.sv -----
// Signed 64-bit integer ALU for an interpreter. Each request beat carries an
// operation code and two operands and yields exactly one response beat, in
// request order, with a wrapped result and an error flag. A front end takes a
// request beat in every cycle that its queue has room and sorts it by the
// unit that will run it; the back end drains the queue, so a response beat
// appears at the earliest in the cycle after the back end takes its request.
// Addition, subtraction, logic, shifts, comparisons and every operation that
// fails or resolves at once (zero divisor, bad shift count, negative
// exponent, unknown code) are handled by the back end without iteration, so
// a stream of them flows at one beat per cycle while the response side does
// not stall. Multiplication loads the operands, forms three 32 by 32 partial
// products on one shared multiplier and hands the result over. Division and
// modulo load the operands, run the 64 steps of the one-bit-per-cycle
// restoring divider and hand the result over. Power loads the operands and,
// for each significant exponent bit, multiplies the result by the base if the
// bit is set and squares the base on the same multiplier, then hands the
// result over. The request queue holds QueueDepth beats, so until it is full
// the front keeps accepting while a long operation runs and while a finished
// response waits in its output register.
module int64_interpreter_alu #(
  parameter int QueueDepth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  ialu_pkg::req_t  req,
  input  logic            req_valid,
  output logic            req_stall,
  output ialu_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_stall
);
  import ialu_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Front end: accepts request beats and queues them with their unit class.
  ialu_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Back end: executes one queued operation at a time into the output register.
  ialu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

// ----- rtl/ialu_front.sv -----
module ialu_front #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  ialu_pkg::req_t  req,
  input  logic            req_valid,
  output logic            req_stall,
  output ialu_pkg::cmd_t  cmd,
  output logic            cmd_valid,
  input  logic            cmd_pop
);
  import ialu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [1:0]      cls;
  logic            push;
  logic            pop;

  // Operations that fail at once or need no iteration go to the simple path.
  always_comb begin
    unique case (req.action)
      OP_MUL: cls = CLS_MUL;
      OP_DIV, OP_MOD: cls = (req.right_operand == '0) ? CLS_SIMPLE : CLS_DIV;
      OP_POW: cls = req.right_operand[63] ? CLS_SIMPLE : CLS_POW;
      default: cls = CLS_SIMPLE;
    endcase
  end

  assign req_stall = (count == CntW'(Depth));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign push      = req_valid && !req_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{cls: cls, req: req};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ialu_back.sv -----
module ialu_back (
  input  logic            clk,
  input  logic            rst,
  input  ialu_pkg::cmd_t  cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  output ialu_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_stall
);
  import ialu_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL      = 3'd1;
  localparam logic [2:0] ST_DIV      = 3'd2;
  localparam logic [2:0] ST_POW_CHK  = 3'd3;
  localparam logic [2:0] ST_POW_MUL  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0]  state;
  logic        out_free;
  logic        rsp_load;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] simple_res;
  logic        simple_err;
  logic [63:0] ua;
  logic [63:0] ub;

  logic [63:0] mx;
  logic [63:0] my;
  logic [1:0]  mstep;
  logic [63:0] macc;
  logic [31:0] mul_l;
  logic [31:0] mul_r;
  logic [63:0] prod;
  logic [63:0] mul_val;

  logic [63:0] pacc;
  logic [63:0] pbase;
  logic [63:0] pexp;
  logic        sq;

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [5:0]  dcnt;
  logic        neg_q;
  logic        neg_r;
  logic        is_mod;
  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        ge;
  logic [63:0] rem_next;
  logic [63:0] quo_next;

  logic [63:0] res;

  assign a        = cmd.req.left_operand;
  assign b        = cmd.req.right_operand;
  assign out_free = !rsp_valid || !rsp_stall;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid && out_free;
  assign ua       = a[63] ? (~a + 64'd1) : a;
  assign ub       = b[63] ? (~b + 64'd1) : b;

  // A new response beat enters the output register in this cycle.
  assign rsp_load = (cmd_pop && (cmd.cls == CLS_SIMPLE)) ||
                    ((state == ST_DONE) && out_free);

  always_comb begin
    simple_res = '0;
    simple_err = 1'b0;
    unique case (cmd.req.action)
      OP_ADD: simple_res = a + b;
      OP_SUB: simple_res = a - b;
      OP_AND: simple_res = a & b;
      OP_OR:  simple_res = a | b;
      OP_XOR: simple_res = a ^ b;
      OP_SHL: begin
        simple_err = (b[63:6] != '0);
        simple_res = a << b[5:0];
      end
      OP_SHR: begin
        simple_err = (b[63:6] != '0);
        simple_res = $unsigned($signed(a) >>> b[5:0]);
      end
      OP_EQ:  simple_res = {63'd0, a == b};
      OP_NEQ: simple_res = {63'd0, a != b};
      OP_LT:  simple_res = {63'd0, $signed(a) < $signed(b)};
      OP_GT:  simple_res = {63'd0, $signed(a) > $signed(b)};
      OP_LTE: simple_res = {63'd0, $signed(a) <= $signed(b)};
      OP_GTE: simple_res = {63'd0, $signed(a) >= $signed(b)};
      OP_LAND: simple_res = {63'd0, (a != '0) && (b != '0)};
      OP_LOR:  simple_res = {63'd0, (a != '0) || (b != '0)};
      // Only a zero divisor reaches here.
      OP_DIV, OP_MOD: simple_err = 1'b1;
      // Only a negative exponent reaches here.
      OP_POW: begin
        if (a == '0) begin
          simple_err = 1'b1;
        end else if (a == 64'd1) begin
          simple_res = 64'd1;
        end else if (&a) begin
          simple_res = b[0] ? '1 : 64'd1;
        end
      end
      OP_MUL: simple_res = '0;
      default: simple_err = 1'b1;
    endcase
    if (simple_err) begin
      simple_res = '0;
    end
  end

  // Low 64 bits of a product from three 32 by 32 partial products.
  always_comb begin
    unique case (mstep)
      2'd0: begin
        mul_l = mx[31:0];
        mul_r = my[31:0];
      end
      2'd1: begin
        mul_l = mx[31:0];
        mul_r = my[63:32];
      end
      default: begin
        mul_l = mx[63:32];
        mul_r = my[31:0];
      end
    endcase
    prod = mul_l * mul_r;
    if (mstep == 2'd0) begin
      mul_val = prod;
    end else begin
      mul_val = {macc[63:32] + prod[31:0], macc[31:0]};
    end
  end

  // One restoring division step.
  assign rem_sh   = {rem, quo[63]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign ge       = !diff[64];
  assign rem_next = ge ? diff[63:0] : rem_sh[63:0];
  assign quo_next = {quo[62:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.cls)
              CLS_SIMPLE: begin
                rsp.result_value <= simple_res;
                rsp.error_flag   <= simple_err;
              end
              CLS_MUL: begin
                mx    <= a;
                my    <= b;
                mstep <= 2'd0;
                state <= ST_MUL;
              end
              CLS_DIV: begin
                rem    <= '0;
                quo    <= ua;
                dvs    <= ub;
                dcnt   <= '0;
                neg_q  <= a[63] ^ b[63];
                neg_r  <= a[63];
                is_mod <= (cmd.req.action == OP_MOD);
                state  <= ST_DIV;
              end
              default: begin
                pacc  <= 64'd1;
                pbase <= a;
                pexp  <= b;
                state <= ST_POW_CHK;
              end
            endcase
          end
        end
        ST_MUL: begin
          macc  <= mul_val;
          mstep <= mstep + 2'd1;
          if (mstep == 2'd2) begin
            res   <= mul_val;
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            if (is_mod) begin
              res <= neg_r ? (~rem_next + 64'd1) : rem_next;
            end else begin
              res <= neg_q ? (~quo_next + 64'd1) : quo_next;
            end
            state <= ST_DONE;
          end
        end
        ST_POW_CHK: begin
          if (pexp == '0) begin
            res   <= pacc;
            state <= ST_DONE;
          end else begin
            mx    <= pexp[0] ? pacc : pbase;
            my    <= pbase;
            sq    <= !pexp[0];
            mstep <= 2'd0;
            state <= ST_POW_MUL;
          end
        end
        ST_POW_MUL: begin
          macc <= mul_val;
          if (mstep == 2'd2) begin
            mstep <= 2'd0;
            if (!sq) begin
              pacc <= mul_val;
              mx   <= pbase;
              my   <= pbase;
              sq   <= 1'b1;
            end else begin
              pbase <= mul_val;
              pexp  <= pexp >> 1;
              state <= ST_POW_CHK;
            end
          end else begin
            mstep <= mstep + 2'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            rsp.result_value <= res;
            rsp.error_flag   <= 1'b0;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ialu_checker.sv -----
`include "assert_macros.svh"

module ialu_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input ialu_pkg::rsp_t rsp
);

  `CHECK_LIVE(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid, "response dropped")
  `CHECK_LIVE(a_rsp_stable, clk, rst, rsp_valid && rsp_stall |=> $stable(rsp), "response changed")
  `CHECK_LIVE(a_err_zero, clk, rst, rsp_valid && rsp.error_flag |-> rsp.result_value == '0, "error with result")
  `CHECK_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "response after reset")

endmodule

bind int64_interpreter_alu ialu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
